// ===== design/morton_range_split_search_assert.svh =====
// ----------------------------------------------------------------------------
// Morton range split search assertion macros
// Concurrent check wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef MORTON_RANGE_SPLIT_SEARCH_ASSERT_SVH
`define MORTON_RANGE_SPLIT_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define MSRS_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define MSRS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define MSRS_ASSERT_SAME(label, clk, rst_n, cond, prop, msg)
`define MSRS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== design/msrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Morton range split search package
// Request and response types, operation codes and shared flag struct.
// ----------------------------------------------------------------------------
package msrs_pkg;

    localparam int INDEX_W = 10;
    localparam int FIELD_CODE_W = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SPLIT = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [INDEX_W-1:0]      entry_index;
        logic [FIELD_CODE_W-1:0] entry_code;
        logic [INDEX_W-1:0]      first_index;
        logic [INDEX_W-1:0]      last_index;
    } t_req;

    typedef struct packed {
        logic [INDEX_W-1:0] split_index;
        logic               ends_equal;
    } t_rsp;

    typedef struct packed {
        logic ends_eq;
        logic prefix_match;
    } t_prefix_flags;

endpackage

// ===== design/morton_range_split_search.sv =====
// ----------------------------------------------------------------------------
// Morton range split search
// Load: written on accept, busy stays low. Query: the result strobe follows state
// CHK for a reversed range, states RDL and LC for equal end codes, else a binary
// search through states STEP and CMP between first and last.
// One request at a time; results cannot be stalled. Synchronous active-low
// reset clears control state only; the table holds no reset value.
// ----------------------------------------------------------------------------
`include "morton_range_split_search_assert.svh"

module morton_range_split_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int CODE_WIDTH  = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  msrs_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_done,
    output msrs_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EXT_W = ((IDX_W > msrs_pkg::INDEX_W) ? IDX_W : msrs_pkg::INDEX_W) + 1;
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(TABLE_DEPTH);
    localparam logic [EXT_W-1:0] MAX_EXT   = EXT_W'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RDL  = 3'd2;
    localparam logic [2:0] S_LC   = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic                  r_done,  n_done;
    msrs_pkg::t_rsp        r_rsp,   n_rsp;
    logic [IDX_W-1:0]      r_first, n_first;
    logic [IDX_W-1:0]      r_last,  n_last;
    logic [IDX_W-1:0]      r_split, n_split;
    logic [IDX_W-1:0]      r_step,  n_step;
    logic [IDX_W-1:0]      r_probe, n_probe;
    logic [CODE_WIDTH-1:0] r_fcode, n_fcode;
    logic [CODE_WIDTH-1:0] r_mask,  n_mask;

    logic                  accept;
    logic [EXT_W-1:0]      load_ext;
    logic [EXT_W-1:0]      first_ext;
    logic [EXT_W-1:0]      last_ext;
    logic                  we;
    logic [IDX_W-1:0]      raddr;
    logic [CODE_WIDTH-1:0] rdata;
    logic [CODE_WIDTH-1:0] smear_mask;
    msrs_pkg::t_prefix_flags flags;
    logic [IDX_W:0]        step_nx;
    logic [IDX_W:0]        probe_nx;
    logic [IDX_W:0]        mid_sum;
    logic [IDX_W-1:0]      split_upd;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign load_ext  = EXT_W'(i_req.entry_index);
    assign first_ext = (EXT_W'(i_req.first_index) >= DEPTH_EXT) ? MAX_EXT
                                                                 : EXT_W'(i_req.first_index);
    assign last_ext  = (EXT_W'(i_req.last_index) >= DEPTH_EXT) ? MAX_EXT
                                                                : EXT_W'(i_req.last_index);
    assign we        = accept && (i_req.op == msrs_pkg::OP_LOAD) && (load_ext < DEPTH_EXT);

    assign step_nx   = ({1'b0, r_step} + (IDX_W+1)'(1)) >> 1;
    assign probe_nx  = {1'b0, r_split} + step_nx;
    assign mid_sum   = {1'b0, r_first} + {1'b0, r_last};
    assign split_upd = flags.prefix_match ? r_probe : r_split;

    always_comb begin
        case (r_state)
            S_CHK:   raddr = r_first;
            S_RDL:   raddr = r_last;
            default: raddr = probe_nx[IDX_W-1:0];
        endcase
    end

    msrs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CODE_WIDTH  (CODE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (load_ext[IDX_W-1:0]),
        .i_wdata (CODE_WIDTH'(i_req.entry_code)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    msrs_prefix #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_prefix (
        .i_a     (r_fcode),
        .i_b     (rdata),
        .i_mask  (r_mask),
        .o_mask  (smear_mask),
        .o_flags (flags)
    );

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        n_first = r_first;
        n_last  = r_last;
        n_split = r_split;
        n_step  = r_step;
        n_probe = r_probe;
        n_fcode = r_fcode;
        n_mask  = r_mask;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req.op == msrs_pkg::OP_SPLIT)) begin
                    n_first = first_ext[IDX_W-1:0];
                    n_last  = last_ext[IDX_W-1:0];
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_first > r_last) begin
                    n_done  = 1'b1;
                    n_rsp   = '{split_index: msrs_pkg::INDEX_W'(r_first), ends_equal: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RDL;
                end
            end
            S_RDL: begin
                n_fcode = rdata;
                n_state = S_LC;
            end
            S_LC: begin
                if (flags.ends_eq) begin
                    n_done  = 1'b1;
                    n_rsp   = '{split_index: msrs_pkg::INDEX_W'(mid_sum >> 1), ends_equal: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_mask  = smear_mask;
                    n_split = r_first;
                    n_step  = r_last - r_first;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_step = step_nx[IDX_W-1:0];
                if (probe_nx < {1'b0, r_last}) begin
                    n_probe = probe_nx[IDX_W-1:0];
                    n_state = S_CMP;
                end else if (step_nx > (IDX_W+1)'(1)) begin
                    n_state = S_STEP;
                end else begin
                    n_done  = 1'b1;
                    n_rsp   = '{split_index: msrs_pkg::INDEX_W'(r_split), ends_equal: 1'b0};
                    n_state = S_IDLE;
                end
            end
            S_CMP: begin
                n_split = split_upd;
                if (r_step > IDX_W'(1)) begin
                    n_state = S_STEP;
                end else begin
                    n_done  = 1'b1;
                    n_rsp   = '{split_index: msrs_pkg::INDEX_W'(split_upd), ends_equal: 1'b0};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp   <= n_rsp;
        r_first <= n_first;
        r_last  <= n_last;
        r_split <= n_split;
        r_step  <= n_step;
        r_probe <= n_probe;
        r_fcode <= n_fcode;
        r_mask  <= n_mask;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `MSRS_ASSERT_SAME(a_done_after_work, i_clk, i_rst_n, o_done,
                      $past(r_state) != S_IDLE, "result without a query in flight")
    `MSRS_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done,
                      "result strobe held for two cycles")
    `MSRS_ASSERT_NEXT(a_query_goes_busy, i_clk, i_rst_n,
                      accept && (i_req.op == msrs_pkg::OP_SPLIT), busy,
                      "query accepted but block not busy")
    `MSRS_ASSERT_SAME(a_split_below_last, i_clk, i_rst_n,
                      (r_state == S_STEP) || (r_state == S_CMP), r_split < r_last,
                      "search split reached last index")

endmodule

// ===== design/msrs_table.sv =====
// ----------------------------------------------------------------------------
// Morton code table
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module msrs_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int CODE_WIDTH  = 32,
    parameter int IDX_W       = 10
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [CODE_WIDTH-1:0] i_wdata,
    input  logic [IDX_W-1:0]      i_raddr,
    output logic [CODE_WIDTH-1:0] o_rdata
);

    logic [CODE_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [CODE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/msrs_prefix.sv =====
// ----------------------------------------------------------------------------
// Shared prefix compare unit
// Compares two codes: equality, a mask from the highest differing bit down and masked prefix match.
// ----------------------------------------------------------------------------
module msrs_prefix #(
    parameter int CODE_WIDTH = 32
) (
    input  logic [CODE_WIDTH-1:0]  i_a,
    input  logic [CODE_WIDTH-1:0]  i_b,
    input  logic [CODE_WIDTH-1:0]  i_mask,
    output logic [CODE_WIDTH-1:0]  o_mask,
    output msrs_pkg::t_prefix_flags o_flags
);

    logic [CODE_WIDTH-1:0] diff;
    logic [CODE_WIDTH-1:0] smear;

    assign diff = i_a ^ i_b;

    // spread the highest differing bit down to bit zero
    always_comb begin
        smear = diff;
        for (int s = 1; s < CODE_WIDTH; s = s * 2) begin
            smear = smear | (smear >> s);
        end
    end

    // match when no bit at or above the highest differing end bit differs
    assign o_mask               = smear;
    assign o_flags.ends_eq      = (diff == '0);
    assign o_flags.prefix_match = ((diff & ~(i_mask >> 1)) == '0);

endmodule
